### rtl/rpca_pkg.sv
// rpca_pkg: shared constants, types and register indexes for the rc pwm
// capture and averaging block; no dependencies
`timescale 1ns / 1ps

package rpca_pkg;

  // fixed geometry
  localparam int NUM_CHANNELS = 4;
  localparam int CH_W         = 2;
  localparam int SLOTS        = 3;
  localparam int SLOT_W       = 2;
  localparam int TS_W         = 32;
  localparam int CFG_W        = 12;
  localparam int CFG_IDX_W    = 1;
  localparam int OUT_W        = 17;

  // defaults for top level parameters
  localparam int WIDTH_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // register reset values
  localparam logic [CFG_W-1:0] RESET_OFFSET    = 12'd1500;
  localparam logic [CFG_W-1:0] RESET_THRESHOLD = 12'd300;

  // divide by three: magnitudes are clamped to 3 * 2^16, then multiplied by
  // ceil(2^19 / 3) and shifted, which is exact over that range
  localparam int              MAG_W       = 18;
  localparam logic [MAG_W-1:0] MAG_CLAMP  = 18'd196608;
  localparam logic [MAG_W-1:0] RECIP_3    = 18'd174763;
  localparam int              RECIP_SHIFT = 19;
  localparam logic [OUT_W-1:0] OUT_POS_MAX = 17'h0FFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CV_THRESHOLD = 1'b1;

  // control part of a command from the front to the back
  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [SLOT_W-1:0] slot;
    logic              falling;
  } cmd_ctl_t;

  // one result transaction
  typedef struct packed {
    logic [OUT_W-1:0] velocity_x;
    logic [OUT_W-1:0] velocity_y;
    logic [OUT_W-1:0] rotation;
    logic             cv_mode;
  } result_t;

endpackage

### rtl/rpca_fifo.sv
// rpca_fifo: small register based queue with push/full and pop/empty sides
// depends on nothing but its parameters
`timescale 1ns / 1ps

module rpca_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

### rtl/rpca_front.sv
// rpca_front: accepts edge events, keeps start times and slot indexes,
// measures pulse widths; uses rpca_pkg
`timescale 1ns / 1ps

module rpca_front #(
  parameter int WIDTH_BITS = rpca_pkg::WIDTH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [rpca_pkg::CH_W-1:0]   channel,
  input  logic                        level,
  input  logic [rpca_pkg::TS_W-1:0]   timestamp_us,
  input  logic                        cmd_full,
  output logic                        cmd_push,
  output rpca_pkg::cmd_ctl_t          cmd_ctl,
  output logic [WIDTH_BITS-1:0]       cmd_width
);

  localparam logic [rpca_pkg::SLOT_W-1:0] LAST_SLOT =
    rpca_pkg::SLOT_W'(rpca_pkg::SLOTS - 1);

  logic [rpca_pkg::TS_W-1:0]   start_time [rpca_pkg::SLOTS][rpca_pkg::NUM_CHANNELS];
  logic [rpca_pkg::SLOT_W-1:0] slot_index [rpca_pkg::NUM_CHANNELS];
  logic [rpca_pkg::SLOT_W-1:0] slot;
  logic [rpca_pkg::SLOT_W-1:0] slot_next;
  logic [rpca_pkg::TS_W-1:0]   raw_width;
  logic                        accept;

  assign full     = cmd_full;
  assign accept   = push && !cmd_full;
  assign cmd_push = accept;

  // current slot of the channel; an out of range index falls back to slot zero
  always_comb begin
    slot = slot_index[channel];
    if (slot > LAST_SLOT) begin
      slot = '0;
    end
    slot_next = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
  end

  // width since the slot's start time, saturated to the width field
  assign raw_width = timestamp_us - start_time[slot][channel];

  always_comb begin
    if ((raw_width >> WIDTH_BITS) != '0) begin
      cmd_width = '1;
    end else begin
      cmd_width = raw_width[WIDTH_BITS-1:0];
    end
    cmd_ctl.ch      = channel;
    cmd_ctl.slot    = slot;
    cmd_ctl.falling = !level;
  end

  // start times and slot indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < rpca_pkg::SLOTS; s++) begin
        for (int c = 0; c < rpca_pkg::NUM_CHANNELS; c++) begin
          start_time[s][c] <= '0;
        end
      end
      for (int c = 0; c < rpca_pkg::NUM_CHANNELS; c++) begin
        slot_index[c] <= '0;
      end
    end else if (accept) begin
      if (level) begin
        start_time[slot][channel] <= timestamp_us;
      end else begin
        slot_index[channel] <= slot_next;
      end
    end
  end

endmodule

### rtl/rpca_back.sv
// rpca_back: width history and the three stage mean pipeline feeding the
// result queue; uses rpca_pkg
`timescale 1ns / 1ps

module rpca_back #(
  parameter int WIDTH_BITS = rpca_pkg::WIDTH_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rpca_pkg::CFG_W-1:0]   pulse_offset,
  input  logic [rpca_pkg::CFG_W-1:0]   cv_threshold,
  input  logic                         cmd_empty,
  input  rpca_pkg::cmd_ctl_t           cmd_ctl,
  input  logic [WIDTH_BITS-1:0]        cmd_width,
  output logic                         cmd_pop,
  input  logic                         res_full,
  output logic                         res_push,
  output rpca_pkg::result_t            res_data
);

  localparam int NCH   = rpca_pkg::NUM_CHANNELS;
  localparam int SUM_W = WIDTH_BITS + 2;
  localparam int DW    = ((SUM_W > rpca_pkg::MAG_W) ? SUM_W : rpca_pkg::MAG_W) + 1;
  localparam int OFF_W = rpca_pkg::CFG_W + 2;
  localparam int MW    = rpca_pkg::MAG_W;
  localparam int PW    = 2 * MW;
  localparam int OW    = rpca_pkg::OUT_W;

  logic [WIDTH_BITS-1:0] hist [rpca_pkg::SLOTS][NCH];
  logic [OFF_W-1:0]      off3;
  logic                  v1, v2, v3;
  logic                  advance;

  logic [DW-1:0] diff_next [NCH];
  logic [DW-1:0] diff      [NCH];
  logic [DW-1:0] abs_d     [NCH];
  logic [MW-1:0] mag_next  [NCH];
  logic [MW-1:0] mag       [NCH];
  logic          neg       [NCH];
  logic [PW-1:0] prod      [NCH];
  logic [OW-1:0] quot      [NCH];
  logic [OW-1:0] mean_out  [NCH];

  // whole pipeline moves unless the last stage is blocked by the result queue
  assign advance  = !(v3 && res_full);
  assign cmd_pop  = advance && !cmd_empty;
  assign res_push = v3 && advance;

  // stage valids and three times the offset
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= cmd_pop;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    off3 <= {1'b0, pulse_offset, 1'b0} + {2'b00, pulse_offset};
  end

  // width history, written by falling edge transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < rpca_pkg::SLOTS; s++) begin
        for (int c = 0; c < NCH; c++) begin
          hist[s][c] <= WIDTH_BITS'(rpca_pkg::RESET_OFFSET);
        end
      end
    end else if (cmd_pop && cmd_ctl.falling) begin
      hist[cmd_ctl.slot][cmd_ctl.ch] <= cmd_width;
    end
  end

  // per channel sum of the three widths minus three offsets
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      diff_next[c] = DW'(hist[0][c]) + DW'(hist[1][c]) + DW'(hist[2][c]) - DW'(off3);
    end
  end

  // magnitude, clamped where the mean would overflow the output anyway
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      abs_d[c] = diff[c][DW-1] ? (~diff[c] + 1'b1) : diff[c];
      if (abs_d[c] >= DW'(rpca_pkg::MAG_CLAMP)) begin
        mag_next[c] = rpca_pkg::MAG_CLAMP;
      end else begin
        mag_next[c] = abs_d[c][MW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int c = 0; c < NCH; c++) begin
        diff[c] <= diff_next[c];
        mag[c]  <= mag_next[c];
        neg[c]  <= diff[c][DW-1];
      end
    end
  end

  // divide by three, restore sign, saturate positive side
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      prod[c] = PW'(mag[c]) * PW'(rpca_pkg::RECIP_3);
      quot[c] = prod[c][rpca_pkg::RECIP_SHIFT +: OW];
      if (neg[c]) begin
        mean_out[c] = ~quot[c] + 1'b1;
      end else if (quot[c] > rpca_pkg::OUT_POS_MAX) begin
        mean_out[c] = rpca_pkg::OUT_POS_MAX;
      end else begin
        mean_out[c] = quot[c];
      end
    end
    res_data.velocity_x = mean_out[0];
    res_data.velocity_y = mean_out[1];
    res_data.rotation   = mean_out[2];
    res_data.cv_mode    = !neg[3] && (quot[3] > OW'(cv_threshold));
  end

endmodule

### rtl/rc_pwm_capture_average.sv
// rc_pwm_capture_average: top level of the four channel rc pwm capture block
// uses rpca_pkg, rpca_front, rpca_fifo and rpca_back
`timescale 1ns / 1ps

// Each pushed edge event (channel, level, timestamp_us) yields exactly one
// result: the truncated means of the last three pulse widths minus
// pulse_offset for channels 0..2, and cv_mode when channel 3's mean exceeds
// cv_threshold. Rising edges record a start time, falling edges record a width
// (saturated to WIDTH_BITS) and move the channel to its next of three slots.
// One event is taken every cycle while the command queue has room; an
// accepted event waits in the command queue, then passes the history write,
// the sum and the magnitude stages, with the divide by three feeding the
// result queue; a full result queue holds these stages. Both queues hold
// QUEUE_DEPTH transactions, so either side can stall without stopping the
// other at once.
// Configuration writes take effect immediately and belong to idle periods.
module rc_pwm_capture_average #(
  parameter int WIDTH_BITS  = rpca_pkg::WIDTH_BITS_DEF,
  parameter int QUEUE_DEPTH = rpca_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [rpca_pkg::CH_W-1:0]       channel,
  input  logic                            level,
  input  logic [rpca_pkg::TS_W-1:0]       timestamp_us,
  output logic                            empty,
  input  logic                            pop,
  output logic signed [rpca_pkg::OUT_W-1:0] velocity_x,
  output logic signed [rpca_pkg::OUT_W-1:0] velocity_y,
  output logic signed [rpca_pkg::OUT_W-1:0] rotation,
  output logic                            cv_mode,
  input  logic                            cfg_we,
  input  logic [rpca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpca_pkg::CFG_W-1:0]      cfg_data
);

  localparam int CTL_W = $bits(rpca_pkg::cmd_ctl_t);
  localparam int CMD_W = CTL_W + WIDTH_BITS;
  localparam int RES_W = $bits(rpca_pkg::result_t);

  logic [rpca_pkg::CFG_W-1:0] pulse_offset;
  logic [rpca_pkg::CFG_W-1:0] cv_threshold;

  logic                  cmd_push;
  logic                  cmd_full;
  logic                  cmd_pop;
  logic                  cmd_empty;
  rpca_pkg::cmd_ctl_t    front_ctl;
  rpca_pkg::cmd_ctl_t    back_ctl;
  logic [WIDTH_BITS-1:0] front_width;
  logic [WIDTH_BITS-1:0] back_width;
  logic [CMD_W-1:0]      cmd_rdata;

  logic                  res_push;
  logic                  res_full;
  rpca_pkg::result_t     res_wdata;
  rpca_pkg::result_t     res_rdata;
  logic [RES_W-1:0]      res_rbits;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_offset <= rpca_pkg::RESET_OFFSET;
      cv_threshold <= rpca_pkg::RESET_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpca_pkg::REG_PULSE_OFFSET: pulse_offset <= cfg_data;
        rpca_pkg::REG_CV_THRESHOLD: cv_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // event intake and width measurement
  rpca_front #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .channel      (channel),
    .level        (level),
    .timestamp_us (timestamp_us),
    .cmd_full     (cmd_full),
    .cmd_push     (cmd_push),
    .cmd_ctl      (front_ctl),
    .cmd_width    (front_width)
  );

  // command queue between front and back
  rpca_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata ({front_ctl, front_width}),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  assign back_ctl   = cmd_rdata[CMD_W-1:WIDTH_BITS];
  assign back_width = cmd_rdata[WIDTH_BITS-1:0];

  // history and mean pipeline
  rpca_back #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pulse_offset (pulse_offset),
    .cv_threshold (cv_threshold),
    .cmd_empty    (cmd_empty),
    .cmd_ctl      (back_ctl),
    .cmd_width    (back_width),
    .cmd_pop      (cmd_pop),
    .res_full     (res_full),
    .res_push     (res_push),
    .res_data     (res_wdata)
  );

  // result queue
  rpca_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rbits),
    .empty (empty)
  );

  assign res_rdata  = res_rbits;
  assign velocity_x = res_rdata.velocity_x;
  assign velocity_y = res_rdata.velocity_y;
  assign rotation   = res_rdata.rotation;
  assign cv_mode    = res_rdata.cv_mode;

endmodule

### dv/rpca_checker.sv
// rpca_checker: watches the edge, result and register ports of the rc pwm
// capture block, predicts each result and compares; depends on rpca_pkg
`timescale 1ns / 1ps

module rpca_checker #(
  parameter int WIDTH_BITS = rpca_pkg::WIDTH_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic                                full,
  input  logic [rpca_pkg::CH_W-1:0]           channel,
  input  logic                                level,
  input  logic [rpca_pkg::TS_W-1:0]           timestamp_us,
  input  logic                                empty,
  input  logic                                pop,
  input  logic signed [rpca_pkg::OUT_W-1:0]   velocity_x,
  input  logic signed [rpca_pkg::OUT_W-1:0]   velocity_y,
  input  logic signed [rpca_pkg::OUT_W-1:0]   rotation,
  input  logic                                cv_mode,
  input  logic                                cfg_we,
  input  logic [rpca_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rpca_pkg::CFG_W-1:0]          cfg_data,
  output int                                  mismatches,
  output int                                  outstanding
);

  localparam longint WIDTH_LIMIT = (longint'(1) << WIDTH_BITS) - 1;
  localparam longint MEAN_MAX    = 65535;
  localparam longint MEAN_MIN    = -65536;

  // shadow copy of the capture state and the two registers
  logic [rpca_pkg::TS_W-1:0]   start_time [rpca_pkg::SLOTS][rpca_pkg::NUM_CHANNELS];
  logic [WIDTH_BITS-1:0]       width_hist [rpca_pkg::SLOTS][rpca_pkg::NUM_CHANNELS];
  logic [rpca_pkg::SLOT_W-1:0] slot_ptr   [rpca_pkg::NUM_CHANNELS];
  logic [rpca_pkg::CFG_W-1:0]  offset_q;
  logic [rpca_pkg::CFG_W-1:0]  thresh_q;

  // predicted averages, oldest first
  rpca_pkg::result_t     means_q [$];
  int                    results_seen;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
  end

  task automatic load_reset_state();
    for (int s = 0; s < rpca_pkg::SLOTS; s++) begin
      for (int c = 0; c < rpca_pkg::NUM_CHANNELS; c++) begin
        start_time[s][c] = '0;
        width_hist[s][c] = WIDTH_BITS'(rpca_pkg::RESET_OFFSET);
      end
    end
    for (int c = 0; c < rpca_pkg::NUM_CHANNELS; c++) slot_ptr[c] = '0;
    offset_q = rpca_pkg::RESET_OFFSET;
    thresh_q = rpca_pkg::RESET_THRESHOLD;
    means_q.delete();
  endtask

  // mean of the three widths minus offset, truncated toward zero
  function automatic longint channel_mean(input int ch);
    longint sum;
    sum = 0;
    for (int s = 0; s < rpca_pkg::SLOTS; s++)
      sum += longint'(width_hist[s][ch]) - longint'(offset_q);
    return sum / rpca_pkg::SLOTS;
  endfunction

  function automatic logic [rpca_pkg::OUT_W-1:0] clamp_mean(input longint m);
    if (m > MEAN_MAX) m = MEAN_MAX;
    if (m < MEAN_MIN) m = MEAN_MIN;
    return rpca_pkg::OUT_W'(m);
  endfunction

  // apply one edge transaction and queue the averages it leads to
  task automatic apply_edge(input logic [rpca_pkg::CH_W-1:0] ch, input logic rising,
                            input logic [rpca_pkg::TS_W-1:0] ts);
    logic [rpca_pkg::SLOT_W-1:0] slot;
    logic [rpca_pkg::TS_W-1:0]   span;
    rpca_pkg::result_t           avg;
    slot = slot_ptr[ch];
    if (slot >= rpca_pkg::SLOTS) slot = '0;
    if (rising) begin
      start_time[slot][ch] = ts;
    end else begin
      span = ts - start_time[slot][ch];
      if (longint'(span) > WIDTH_LIMIT) width_hist[slot][ch] = '1;
      else width_hist[slot][ch] = WIDTH_BITS'(span);
      slot_ptr[ch] = (slot == rpca_pkg::SLOT_W'(rpca_pkg::SLOTS - 1)) ? '0 : slot + 1'b1;
    end
    avg.velocity_x = clamp_mean(channel_mean(0));
    avg.velocity_y = clamp_mean(channel_mean(1));
    avg.rotation   = clamp_mean(channel_mean(2));
    avg.cv_mode    = channel_mean(3) > longint'(thresh_q);
    means_q.push_back(avg);
  endtask

  task automatic report_mismatch(input string what,
                                 input logic [rpca_pkg::OUT_W-1:0] want,
                                 input logic [rpca_pkg::OUT_W-1:0] got);
    $display("rpca_checker: result %0d %s: expected %0d got %0d",
             results_seen, what, $signed(want), $signed(got));
    mismatches++;
  endtask

  task automatic check_field(input string what,
                             input logic [rpca_pkg::OUT_W-1:0] want,
                             input logic [rpca_pkg::OUT_W-1:0] got);
    if (want !== got) report_mismatch(what, want, got);
  endtask

  // result side is checked before the edge side so a transaction cannot
  // match an expectation queued at the same clock edge
  always @(posedge clk) begin : watch_ports
    rpca_pkg::result_t want;
    if (rst) begin
      load_reset_state();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rpca_pkg::REG_PULSE_OFFSET: offset_q = cfg_data;
          rpca_pkg::REG_CV_THRESHOLD: thresh_q = cfg_data;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        results_seen++;
        if (means_q.size() == 0) begin
          report_mismatch("arrived with nothing pending", '0, velocity_x);
        end else begin
          want = means_q.pop_front();
          check_field("velocity_x", want.velocity_x, velocity_x);
          check_field("velocity_y", want.velocity_y, velocity_y);
          check_field("rotation", want.rotation, rotation);
          check_field("cv_mode", {{(rpca_pkg::OUT_W-1){1'b0}}, want.cv_mode},
                      {{(rpca_pkg::OUT_W-1){1'b0}}, cv_mode});
        end
      end
      if (push && !full) apply_edge(channel, level, timestamp_us);
    end
    outstanding = means_q.size();
  end

endmodule

### dv/tb_top.sv
// tb_top: stimulus, clock, reset and verdict for rc_pwm_capture_average
// depends on rpca_pkg, rc_pwm_capture_average and rpca_checker
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 250;

  logic                           clk          = 1'b0;
  logic                           rst          = 1'b1;
  logic                           push         = 1'b0;
  logic                           full;
  logic [rpca_pkg::CH_W-1:0]      channel      = '0;
  logic                           level        = 1'b0;
  logic [rpca_pkg::TS_W-1:0]      timestamp_us = '0;
  logic                           empty;
  logic                           pop          = 1'b0;
  logic signed [rpca_pkg::OUT_W-1:0] velocity_x;
  logic signed [rpca_pkg::OUT_W-1:0] velocity_y;
  logic signed [rpca_pkg::OUT_W-1:0] rotation;
  logic                           cv_mode;
  logic                           cfg_we       = 1'b0;
  logic [rpca_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
  logic [rpca_pkg::CFG_W-1:0]     cfg_data     = '0;

  int                   mismatches;
  int                   outstanding;
  int                   idle_cycles  = 0;

  // when set, that side takes no pauses between transactions
  logic                 push_steady  = 1'b0;
  logic                 pop_steady   = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rc_pwm_capture_average uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .channel      (channel),
    .level        (level),
    .timestamp_us (timestamp_us),
    .empty        (empty),
    .pop          (pop),
    .velocity_x   (velocity_x),
    .velocity_y   (velocity_y),
    .rotation     (rotation),
    .cv_mode      (cv_mode),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  rpca_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .channel      (channel),
    .level        (level),
    .timestamp_us (timestamp_us),
    .empty        (empty),
    .pop          (pop),
    .velocity_x   (velocity_x),
    .velocity_y   (velocity_y),
    .rotation     (rotation),
    .cv_mode      (cv_mode),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // watchdog: ends the run after a long stretch with no transaction at all
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls before each pop unless pop_steady, pop held high until taken
  initial begin : result_drain
    int gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      gap = pop_steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // one edge transaction, after a random pause unless push_steady is set
  task automatic send_edge(input logic [rpca_pkg::CH_W-1:0] ch, input logic lvl,
                           input logic [rpca_pkg::TS_W-1:0] ts);
    int gap;
    gap = push_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    channel      <= ch;
    level        <= lvl;
    timestamp_us <= ts;
    do @(posedge clk); while (full);
  endtask

  task automatic send_pulse(input logic [rpca_pkg::CH_W-1:0] ch,
                            input logic [rpca_pkg::TS_W-1:0] t0,
                            input logic [rpca_pkg::TS_W-1:0] span);
    send_edge(ch, 1'b1, t0);
    send_edge(ch, 1'b0, t0 + span);
  endtask

  // stop sending and wait until every result is back and the pipe is empty
  task automatic settle();
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [rpca_pkg::CFG_W-1:0] offset,
                              input logic [rpca_pkg::CFG_W-1:0] thresh);
    cfg_we    <= 1'b1;
    cfg_index <= rpca_pkg::REG_PULSE_OFFSET;
    cfg_data  <= offset;
    @(posedge clk);
    cfg_index <= rpca_pkg::REG_CV_THRESHOLD;
    cfg_data  <= thresh;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly servo-like widths, with saturation edges and wild values mixed in
  function automatic logic [rpca_pkg::TS_W-1:0] pulse_span();
    case ($urandom_range(0, 11))
      0:       return $urandom_range(0, 4095);
      1:       return $urandom_range(65530, 65541);
      2:       return $urandom();
      3:       return $urandom_range(60000, 70000);
      default: return $urandom_range(900, 2100);
    endcase
  endfunction

  task automatic run_random(input int n);
    int sent;
    int rounds;
    logic [rpca_pkg::CH_W-1:0] ch;
    sent   = 0;
    rounds = 0;
    while (sent < n) begin
      // new pacing on each side now and then
      if (rounds % 24 == 0) begin
        push_steady = ($urandom_range(0, 3) == 0);
        pop_steady  = ($urandom_range(0, 3) == 0);
      end
      rounds++;
      ch = rpca_pkg::CH_W'($urandom_range(0, 3));
      if ($urandom_range(0, 9) < 2) begin
        // lone edge with arbitrary time: breaks the rising/falling pairing
        send_edge(ch, 1'($urandom_range(0, 1)), $urandom());
        sent += 1;
      end else begin
        send_pulse(ch, $urandom(), pulse_span());
        sent += 2;
      end
    end
  endtask

  initial begin : stimulus
    logic [rpca_pkg::CFG_W-1:0] phase_offset [PHASES];
    logic [rpca_pkg::CFG_W-1:0] phase_thresh [PHASES];
    phase_offset = '{12'd1500, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd0};
    phase_thresh = '{12'd300, 12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0};
    for (int p = PHASES - 2; p < PHASES; p++) begin
      phase_offset[p] = rpca_pkg::CFG_W'($urandom_range(0, 4095));
      phase_thresh[p] = rpca_pkg::CFG_W'($urandom_range(0, 4095));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, register values straight out of reset
    // falling edges with no rising edge measure from a zero start time
    send_edge(2'd0, 1'b0, 32'd100);
    send_edge(2'd0, 1'b0, 32'd0);
    send_edge(2'd0, 1'b0, 32'hFFFF_FFFF);
    // timestamp wrap inside a pulse
    send_pulse(2'd1, 32'hFFFF_FF00, 32'h0000_0110);
    // exactly the widest width, one past it, and far past it
    send_pulse(2'd2, 32'd1000, 32'd65535);
    send_pulse(2'd2, 32'd5000, 32'd65536);
    send_pulse(2'd2, 32'd0, 32'd70000);
    // fill all three slots of the mode channel above threshold
    send_pulse(2'd3, 32'd10, 32'd2000);
    send_pulse(2'd3, 32'd50000, 32'd2000);
    send_pulse(2'd3, 32'hFFFF_FFFF, 32'd2000);
    // zero width lands in the wrapped mode channel slot and drops the mean
    send_pulse(2'd3, 32'd7, 32'd0);
    // repeated rising edge overwrites the start, then two falls in a row
    send_edge(2'd1, 1'b1, 32'd500);
    send_edge(2'd1, 1'b1, 32'd600);
    send_edge(2'd1, 1'b0, 32'd2100);
    send_edge(2'd1, 1'b0, 32'd3000);
    settle();

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      program_regs(phase_offset[p], phase_thresh[p]);
      run_random(PHASE_ITEMS);
      settle();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/rpca_pkg.sv
rtl/rpca_fifo.sv
rtl/rpca_front.sv
rtl/rpca_back.sv
rtl/rc_pwm_capture_average.sv
dv/rpca_checker.sv
dv/tb_top.sv
